>>> hw/rtl/crc8_escaped_frame_deframer_top_defines.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion wrappers used by the deframer top level. Define
// ASSERT_OFF to compile the assertions out.
// ----------------------------------------------------------------------------
`ifndef CRC8_ESCAPED_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define CRC8_ESCAPED_FRAME_DEFRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks that a property holds at every clock edge outside of reset.
`define CRCEFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("deframer assertion failed");
// Checks that a consequent holds in the cycle after its antecedent.
`define CRCEFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define CRCEFD_ASSERT(label, clk, rst, prop)
`define CRCEFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/crcefd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Frame marker codes, result kinds, beat and result types and the CRC-8
// byte update shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package crcefd_pkg;

   // Frame markers and byte stuffing.
   localparam logic [7:0] SOF_BYTE = 8'hA5;
   localparam logic [7:0] EOF_BYTE = 8'h5A;
   localparam logic [7:0] ESC_BYTE = 8'hD0;
   localparam logic [7:0] ESC_XOR  = 8'hE0;

   // CRC-8, polynomial x^8 + x^2 + x + 1, zero init, not reflected.
   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   // Reset value of the parameter count limit.
   localparam logic [7:0] MAX_PARAM_COUNT_RESET = 8'd128;

   // Number of header bytes (type and tag) ahead of the parameters, plus CRC.
   localparam int unsigned HDR_BYTES = 7;

   // Result kind carried on tuser.
   localparam logic KIND_PARAM   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Verdict status.
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // One received beat.
   typedef struct packed {
      logic       last;
      logic [7:0] rx_byte;
   } beat_type;

   // Result payload, packed so that param_byte sits in the lowest bits.
   typedef struct packed {
      logic        status;
      logic [7:0]  param_count;
      logic [31:0] frame_tag;
      logic [15:0] frame_type;
      logic [6:0]  param_index;
      logic [7:0]  param_byte;
   } payload_type;

   // One result beat.
   typedef struct packed {
      logic        kind;
      payload_type payload;
   } rsp_type;

   // Frame tracking flags exported by the core.
   typedef struct packed {
      logic at_start;
      logic escape_pending;
   } frame_state_type;

   // Advances the CRC over one byte, one bit per step.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((acc & CRC_MSB) != 8'd0) begin
            acc = {acc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/crc8_escaped_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// Byte-stuffed frame deframer with CRC-8
// Checks frame markers, removes escapes, captures type and tag, forwards
// parameter bytes provisionally and closes each frame with a verdict.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat and sustains one beat per clock
// cycle while the result queue has room. A beat is held in the input register,
// where the unstuffing, header capture and the CRC-8 byte update run, and its
// result is written into a two-entry result queue that drives rsp_, so a
// stalled result side holds the input only once both entries are full. There
// is no clearing pass after reset; the length limit register resets to 128 and
// is to be written through csr_ while idle; the block does not enforce this.
`default_nettype none
`include "crc8_escaped_frame_deframer_top_defines.svh"

module crc8_escaped_frame_deframer_top #(
   parameter int unsigned MAX_PARAM = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] param_byte, [14:8] param_index,
                                    // [30:15] frame_type, [62:31] frame_tag,
                                    // [70:63] param_count, [71] status
   output logic        rsp_tuser,   // [0] kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] max_param_count
);
   import crcefd_pkg::*;

   logic            limit_written_ff;
   logic [7:0]      max_len_ff;
   beat_type        in_beat;
   beat_type        beat;
   logic            beat_valid;
   logic            advance;
   logic            buf_ready;
   rsp_type         result;
   logic            result_valid;
   rsp_type         head;
   frame_state_type frame_state;

   // Length limit register, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff       <= MAX_PARAM_COUNT_RESET;
         limit_written_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         max_len_ff       <= csr_data;
         limit_written_ff <= 1'b1;
      end
   end

   assign in_beat.rx_byte = req_tdata;
   assign in_beat.last    = req_tlast;

   // The held beat moves on whenever the result queue has room.
   assign advance = beat_valid && buf_ready;

   crcefd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_beat    (in_beat),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   crcefd_core #(
      .MAX_PARAM (MAX_PARAM)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .beat            (beat),
      .fire            (advance),
      .max_param_count (max_len_ff),
      .result          (result),
      .result_valid    (result_valid),
      .frame_state     (frame_state)
   );

   crcefd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (advance && result_valid),
      .push_data  (result),
      .push_ready (buf_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (head)
   );

   assign rsp_tdata = head.payload;
   assign rsp_tuser = head.kind;

   // A verdict always leaves the frame tracker waiting for an opening byte.
   `CRCEFD_ASSERT_NEXT(a_verdict_clears, clock, reset,
      advance && beat.last,
      frame_state.at_start && !frame_state.escape_pending)
   // A parameter byte is never produced for the opening byte of a frame.
   `CRCEFD_ASSERT(a_no_param_at_start, clock, reset,
      !(advance && result_valid && result.kind == KIND_PARAM && frame_state.at_start))
   // A held beat that cannot move on stays in the input register unchanged.
   `CRCEFD_ASSERT_NEXT(a_in_hold, clock, reset,
      beat_valid && !advance,
      beat_valid && $stable(beat))
   // The limit register only changes through a csr write.
   `CRCEFD_ASSERT_NEXT(a_limit_hold, clock, reset,
      !(csr_valid && csr_ready) && limit_written_ff,
      $stable(max_len_ff))

endmodule

`default_nettype wire

>>> hw/rtl/crcefd_in_stage.sv
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one received beat and releases it when the core advances.
// ----------------------------------------------------------------------------
`default_nettype none

module crcefd_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  crcefd_pkg::beat_type in_beat,
   input  logic                advance,
   output logic                beat_valid,
   output crcefd_pkg::beat_type beat
);
   import crcefd_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;

   // The stage takes a new beat when empty or when its beat moves on.
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

`default_nettype wire

>>> hw/rtl/crcefd_core.sv
// ----------------------------------------------------------------------------
// Deframer core
// Frame state, unstuffing, header capture, CRC-8 and the verdict for the
// beat held in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crcefd_core #(
   parameter int unsigned MAX_PARAM = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  crcefd_pkg::beat_type       beat,
   input  logic                       fire,
   input  logic [7:0]                 max_param_count,
   output crcefd_pkg::rsp_type        result,
   output logic                       result_valid,
   output crcefd_pkg::frame_state_type frame_state
);
   import crcefd_pkg::*;

   localparam int unsigned FRAME_MAX = MAX_PARAM + HDR_BYTES;
   // The count saturates one above the longest legal frame.
   localparam int unsigned CNT_W     = $clog2(FRAME_MAX + 2);
   localparam int unsigned EXT_W     = CNT_W + 8;

   logic             at_start_ff, at_start_in;
   logic             escape_ff, escape_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       crc_ff, crc_in;
   logic [15:0]      type_ff, type_in;
   logic [31:0]      tag_ff, tag_in;
   logic             reject_ff, reject_in;

   logic             take;
   logic             emit;
   logic             verdict;
   logic             rej;
   logic [7:0]       ub;
   logic [EXT_W-1:0] pos_ext;
   logic [EXT_W-1:0] idx_ext;
   logic [EXT_W-1:0] plen_ext;

   // Decode the beat against the current frame state.
   always_comb begin
      verdict  = beat.last;
      take     = !at_start_ff && !beat.last && (escape_ff || beat.rx_byte != ESC_BYTE);
      ub       = escape_ff ? (beat.rx_byte ^ ESC_XOR) : beat.rx_byte;
      pos_ext  = EXT_W'(count_ff);
      idx_ext  = pos_ext - EXT_W'(HDR_BYTES);
      emit     = take && (pos_ext >= EXT_W'(HDR_BYTES)) &&
                 (idx_ext < EXT_W'(MAX_PARAM)) && !reject_ff;
      plen_ext = (pos_ext >= EXT_W'(HDR_BYTES)) ? idx_ext : '0;
      if (plen_ext > EXT_W'(MAX_PARAM)) begin
         plen_ext = EXT_W'(MAX_PARAM);
      end
      rej = reject_ff || at_start_ff || (beat.rx_byte != EOF_BYTE) || escape_ff ||
            (pos_ext < EXT_W'(HDR_BYTES + 1)) || (pos_ext > EXT_W'(FRAME_MAX)) ||
            (crc_ff != held_ff) || (plen_ext > EXT_W'(max_param_count));
   end

   // Result for this beat.
   always_comb begin
      result.kind                = verdict ? KIND_VERDICT : KIND_PARAM;
      result.payload.param_byte  = verdict ? 8'd0 : held_ff;
      result.payload.param_index = verdict ? 7'd0 : idx_ext[6:0];
      result.payload.frame_type  = type_ff;
      result.payload.frame_tag   = tag_ff;
      result.payload.param_count = verdict ? plen_ext[7:0] : 8'd0;
      result.payload.status      = (verdict && rej) ? STATUS_REJECT : STATUS_OK;
      result_valid               = verdict || emit;
   end

   // Next frame state.
   always_comb begin
      at_start_in = at_start_ff;
      escape_in   = escape_ff;
      count_in    = count_ff;
      held_in     = held_ff;
      crc_in      = crc_ff;
      type_in     = type_ff;
      tag_in      = tag_ff;
      reject_in   = reject_ff;
      if (verdict) begin
         // Every verdict returns the frame state to idle.
         at_start_in = 1'b1;
         escape_in   = 1'b0;
         count_in    = '0;
         held_in     = 8'd0;
         crc_in      = 8'd0;
         type_in     = 16'd0;
         tag_in      = 32'd0;
         reject_in   = 1'b0;
      end else if (at_start_ff) begin
         at_start_in = 1'b0;
         if (beat.rx_byte != SOF_BYTE) begin
            reject_in = 1'b1;
         end
      end else if (!escape_ff && beat.rx_byte == ESC_BYTE) begin
         escape_in = 1'b1;
      end else begin
         // One unstuffed content byte.
         escape_in = 1'b0;
         if (pos_ext < EXT_W'(2)) begin
            type_in = {type_ff[7:0], ub};
         end else if (pos_ext < EXT_W'(6)) begin
            tag_in = {tag_ff[23:0], ub};
         end
         if (count_ff != '0) begin
            crc_in = crc8_update(crc_ff, held_ff);
         end
         held_in = ub;
         if (pos_ext <= EXT_W'(FRAME_MAX)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         escape_ff   <= 1'b0;
         count_ff    <= '0;
         held_ff     <= 8'd0;
         crc_ff      <= 8'd0;
         type_ff     <= 16'd0;
         tag_ff      <= 32'd0;
         reject_ff   <= 1'b0;
      end else if (fire) begin
         at_start_ff <= at_start_in;
         escape_ff   <= escape_in;
         count_ff    <= count_in;
         held_ff     <= held_in;
         crc_ff      <= crc_in;
         type_ff     <= type_in;
         tag_ff      <= tag_in;
         reject_ff   <= reject_in;
      end
   end

   assign frame_state.at_start       = at_start_ff;
   assign frame_state.escape_pending = escape_ff;

endmodule

`default_nettype wire

>>> hw/rtl/crcefd_out_buf.sv
// ----------------------------------------------------------------------------
// Deframer result buffer
// Two-entry result queue that decouples the core from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module crcefd_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crcefd_pkg::rsp_type push_data,
   output logic               push_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output crcefd_pkg::rsp_type out_data
);
   import crcefd_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign out_valid  = (count_ff != 2'd0);
   assign out_data   = head_ff;
   assign pop        = out_valid && out_ready;

   // Queue update: the head always holds the oldest beat.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push && !pop) begin
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (pop && push) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = tail_ff;
            tail_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

>>> tb/crcefd_verdict_monitor.sv
// ----------------------------------------------------------------------------
// Deframer result monitor
// Watches the receive, result and limit-register channels of the deframer,
// tracks the frame state byte by byte, predicts every parameter and verdict
// beat, and compares each delivered result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module crcefd_verdict_monitor #(
   parameter int unsigned MAX_PARAM = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // [7:0] param_byte, [14:8] param_index,
                                    // [30:15] frame_type, [62:31] frame_tag,
                                    // [70:63] param_count, [71] status
   input  logic        rsp_tuser,   // [0] kind
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,    // [7:0] max_param_count
   output int          fail_count,
   output int          pending_count
);
   import crcefd_pkg::*;

   localparam int unsigned FRAME_MAX = MAX_PARAM + HDR_BYTES;

   // Tracked copy of the limit register and of the frame in progress.
   logic [7:0]  limit_reg;
   bit          first_beat;
   bit          esc_open;
   bit          rejected;
   int unsigned ucount;
   logic [7:0]  held;
   logic [7:0]  crc_run;
   logic [15:0] type_cap;
   logic [31:0] tag_cap;

   // Results predicted but not yet delivered, oldest first.
   rsp_type     rsp_due_q[$];
   int          mismatches = 0;

   // CRC-8, polynomial 0x07, MSB first.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
   endfunction

   function automatic void clear_frame();
      first_beat = 1'b1;
      esc_open = 1'b0;
      rejected = 1'b0;
      ucount = 0;
      held = '0;
      crc_run = '0;
      type_cap = '0;
      tag_cap = '0;
   endfunction

   // Consumes one unstuffed byte. The newest byte is held back as the CRC
   // candidate; the byte it displaces is released as a parameter if allowed.
   function automatic bit take_unstuffed(input logic [7:0] b, output logic [7:0] val,
                                         output logic [6:0] idx);
      int unsigned pos;
      bit emit;
      pos = ucount;
      emit = 1'b0;
      val = '0;
      idx = '0;
      if (pos < 2) begin
         type_cap = {type_cap[7:0], b};
      end else if (pos < 6) begin
         tag_cap = {tag_cap[23:0], b};
      end
      if (pos >= 1) begin
         crc_run = crc8_step(crc_run, held);
         if (pos >= HDR_BYTES && pos - HDR_BYTES < MAX_PARAM && !rejected) begin
            val = held;
            idx = 7'(pos - HDR_BYTES);
            emit = 1'b1;
         end
      end
      held = b;
      // The count saturates one above the longest legal frame.
      if (ucount <= FRAME_MAX) ucount++;
      return emit;
   endfunction

   // Advances the frame by one received byte; returns 1 when a result is due.
   function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                       output rsp_type r);
      logic [7:0]  val;
      logic [6:0]  idx;
      bit          emit;
      bit          rej;
      int unsigned plen;
      r = '0;
      val = '0;
      idx = '0;
      emit = 1'b0;
      if (first_beat) begin
         first_beat = 1'b0;
         if (b != SOF_BYTE) rejected = 1'b1;
         if (!last) return 1'b0;
         // A buffer of the opening byte alone is always rejected.
         rejected = 1'b1;
      end else if (!last) begin
         if (esc_open) begin
            esc_open = 1'b0;
            emit = take_unstuffed(b ^ ESC_XOR, val, idx);
         end else if (b == ESC_BYTE) begin
            esc_open = 1'b1;
         end else begin
            emit = take_unstuffed(b, val, idx);
         end
         if (emit) begin
            r.kind = KIND_PARAM;
            r.payload.param_byte = val;
            r.payload.param_index = idx;
            r.payload.frame_type = type_cap;
            r.payload.frame_tag = tag_cap;
         end
         return emit;
      end

      // Closing byte: build the verdict and start over.
      rej = rejected;
      if (b != EOF_BYTE || esc_open) rej = 1'b1;
      if (ucount < HDR_BYTES + 1 || ucount > FRAME_MAX) rej = 1'b1;
      if (crc_run != held) rej = 1'b1;
      plen = (ucount >= HDR_BYTES) ? ucount - HDR_BYTES : 0;
      if (plen > MAX_PARAM) plen = MAX_PARAM;
      if (plen > limit_reg) rej = 1'b1;
      r.kind = KIND_VERDICT;
      r.payload.frame_type = type_cap;
      r.payload.frame_tag = tag_cap;
      r.payload.param_count = 8'(plen);
      r.payload.status = rej ? STATUS_REJECT : STATUS_OK;
      clear_frame();
      return 1'b1;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Sample all three channels at each rising edge.
   always @(posedge clock) begin
      rsp_type     want;
      payload_type got;
      if (reset) begin
         clear_frame();
         limit_reg = MAX_PARAM_COUNT_RESET;
         rsp_due_q.delete();
      end else begin
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_tvalid && req_tready) begin
            if (deframe_byte(req_tdata, req_tlast, want)) rsp_due_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = payload_type'(rsp_tdata);
            if (rsp_due_q.size() == 0) begin
               $error("result beat with nothing expected: kind %0b data 0x%0h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = rsp_due_q.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("param_byte", want.payload.param_byte, got.param_byte);
               check_field("param_index", want.payload.param_index, got.param_index);
               check_field("frame_type", want.payload.frame_type, got.frame_type);
               check_field("frame_tag", want.payload.frame_tag, got.frame_tag);
               check_field("param_count", want.payload.param_count, got.param_count);
               check_field("status", want.payload.status, got.status);
            end
         end
      end
      pending_count <= rsp_due_q.size();
      fail_count <= mismatches;
   end

endmodule

>>> tb/crc8_escaped_frame_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// Deframer testbench
// Sends byte-stuffed frames, good and broken, through the deframer under
// several parameter length limits, with random gaps and result back-pressure,
// and reports the verdict of the result monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module crc8_escaped_frame_deframer_top_tb;
   import crcefd_pkg::*;

   localparam int unsigned MAX_PARAM   = 128;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          PHASE_BYTES = 100;

   typedef enum int {
      FR_GOOD, FR_BAD_SOF, FR_BAD_EOF, FR_BAD_CRC, FR_OPEN_ESC, FR_SHORT, FR_NOISE,
      FR_SINGLE
   } frame_flavor_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   int          fail_count;
   int          pending_count;
   int          cycles = 0;
   int          bytes_sent = 0;
   bit          steady = 1'b0;
   logic [7:0]  limits[6];

   crc8_escaped_frame_deframer_top #(.MAX_PARAM(MAX_PARAM)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   crcefd_verdict_monitor #(.MAX_PARAM(MAX_PARAM)) monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side back-pressure, switched off during the steady phase.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 11);
   end

   // Presents one byte and waits until it is taken.
   task automatic send_byte(input logic [7:0] b, input logic l);
      if (!steady && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Builds a frame with n parameter bytes (fill < 0 gives random content),
   // damages it as the flavor asks, stuffs it and sends it.
   task automatic send_frame(input frame_flavor_type flavor, input int n,
                             input logic [15:0] ftype, input logic [31:0] ftag,
                             input int fill);
      logic [7:0] body[$];
      logic [7:0] stuffed[$];
      logic [7:0] crc;
      logic [7:0] c;
      for (int i = 1; i >= 0; i--) body.push_back(ftype[8*i +: 8]);
      for (int i = 3; i >= 0; i--) body.push_back(ftag[8*i +: 8]);
      for (int i = 0; i < n; i++) body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      crc = '0;
      foreach (body[i]) crc = crc8_update(crc, body[i]);
      if (flavor == FR_BAD_CRC) crc ^= 8'($urandom_range(1, 255));
      body.push_back(crc);
      if (flavor == FR_SHORT) begin
         body.delete();
         repeat ($urandom_range(0, 7)) body.push_back(8'($urandom));
      end

      // Opening marker.
      c = SOF_BYTE;
      if (flavor == FR_BAD_SOF) begin
         do c = 8'($urandom); while (c == SOF_BYTE);
      end
      stuffed.push_back(c);

      // Markers and escapes must be escaped; other bytes now and then too.
      foreach (body[i]) begin
         c = body[i];
         if (c == ESC_BYTE || c == SOF_BYTE || c == EOF_BYTE || $urandom_range(0, 15) == 0) begin
            stuffed.push_back(ESC_BYTE);
            stuffed.push_back(c ^ ESC_XOR);
         end else begin
            stuffed.push_back(c);
         end
      end
      if (flavor == FR_OPEN_ESC) stuffed.push_back(ESC_BYTE);

      // Closing marker.
      c = EOF_BYTE;
      if (flavor == FR_BAD_EOF) begin
         do c = 8'($urandom); while (c == EOF_BYTE);
      end
      stuffed.push_back(c);

      if (flavor == FR_NOISE) begin
         stuffed.delete();
         repeat ($urandom_range(1, 6)) stuffed.push_back(8'($urandom));
      end
      if (flavor == FR_SINGLE) begin
         stuffed.delete();
         stuffed.push_back(SOF_BYTE);
      end
      foreach (stuffed[i]) send_byte(stuffed[i], i == stuffed.size() - 1);
   endtask

   // Mostly good frames with small parameter fields; the rest are damaged,
   // sit at the limit, or run past the longest legal frame.
   task automatic random_frame(input logic [7:0] limit);
      int               pick;
      int               n;
      frame_flavor_type flavor;
      pick = $urandom_range(0, 19);
      flavor = (pick >= 1 && pick <= 7) ? frame_flavor_type'(pick) : FR_GOOD;
      case ($urandom_range(0, 39))
         0: n = 0;
         1: n = (limit > MAX_PARAM) ? MAX_PARAM : limit;
         2: n = (limit >= MAX_PARAM) ? MAX_PARAM + 1 : limit + 1;
         3: n = ($urandom_range(0, 2) == 0) ? MAX_PARAM + 7 : MAX_PARAM + $urandom_range(0, 1);
         default: n = $urandom_range(1, 12);
      endcase
      send_frame(flavor, n, 16'($urandom), $urandom, -1);
   endtask

   // Lets the block drain before touching the limit register.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      limits = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd128, 8'd7};
      limits[3] = 8'($urandom_range(2, 127));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset limit: a lone opening byte, all-ones
      // and all-zeros fields, an open escape and a bad opening byte.
      send_frame(FR_SINGLE, 0, 16'h0000, 32'h0000_0000, -1);
      send_frame(FR_GOOD, 1, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
      send_frame(FR_GOOD, 0, 16'h0000, 32'h0000_0000, -1);
      send_frame(FR_OPEN_ESC, 1, 16'h00D0, 32'hA55A_D030, 8'h00);
      send_frame(FR_BAD_SOF, 1, 16'h1234, 32'h89AB_CDEF, 8'h5A);

      // Random frames under each limit; one phase runs without any gaps.
      foreach (limits[p]) begin
         wait_idle();
         steady <= (p == 2);
         write_limit(limits[p]);
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) random_frame(limits[p]);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
